// File: src/weo_pkg.sv
// Shared widths, register codes, reset values and constants of the wheel odometry block.
package weo_pkg;

	// Default structural parameters.
	localparam int ENCODER_BITS_DEF = 15;
	localparam int HEADING_BITS_DEF = 16;

	// Fixed field widths.
	localparam int MPC_W  = 24;
	localparam int GAIN_W = 16;
	localparam int THR_W  = 15;
	localparam int SPAN_W = 15;
	localparam int POSE_W = 32;
	localparam int LIN_W  = 21;
	localparam int ANG_W  = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROLLOVER_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_SPAN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REVERSED     = 3'd4;

	localparam logic [MPC_W-1:0]  RST_METRES_PER_COUNT   = 24'd23270;
	localparam logic [GAIN_W-1:0] RST_HEADING_GAIN       = 16'd24834;
	localparam logic [THR_W-1:0]  RST_ROLLOVER_THRESHOLD = 15'd1000;
	localparam logic [SPAN_W-1:0] RST_ENCODER_SPAN       = 15'd32767;
	localparam logic              RST_RIGHT_REVERSED     = 1'b1;

	// Fixed point shifts of the step conversion.
	localparam int LIN_SHIFT = 9;
	localparam int DIF_SHIFT = 8;

	// Shared multiplier: width of the second operand, and the split used for long operands.
	localparam int MUL_B_W = 32;
	localparam int SPLIT_W = 16;

	// Sine evaluation: 32-bit turn phase, Q2.30 values.
	localparam int PHASE_W    = 32;
	localparam int TRIG_SHIFT = 30;
	localparam int TM_W       = TRIG_SHIFT + 1;
	localparam int TRIG_W     = TM_W + 1;
	localparam logic [TM_W-1:0] Q30_ONE = 31'h4000_0000;

	// Horner coefficients of the quarter-wave sine polynomial, innermost first.
	localparam logic [MUL_B_W-1:0] HC0 = 32'd172272;
	localparam logic [MUL_B_W-1:0] HC1 = 32'd5026995;
	localparam logic [MUL_B_W-1:0] HC2 = 32'd85569306;
	localparam logic [MUL_B_W-1:0] HC3 = 32'd693598668;
	localparam logic [MUL_B_W-1:0] HC4 = 32'd1686629713;

	typedef struct packed {
		logic [MPC_W-1:0]  metres_per_count;
		logic [GAIN_W-1:0] heading_gain;
		logic [THR_W-1:0]  rollover_threshold;
		logic [SPAN_W-1:0] encoder_span;
		logic              right_reversed;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic acc;
	} mul_ctl_t;

endpackage

// File: src/weo_cfg_if.sv
// Configuration write channel: register index and write data.
interface weo_cfg_if;
	import weo_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/weo_in_if.sv
// Sample channel: one left and one right raw encoder count per item.
interface weo_in_if #(
	parameter int ENCODER_BITS = weo_pkg::ENCODER_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [ENCODER_BITS-1:0] left_position;
	logic [ENCODER_BITS-1:0] right_position;

	modport source (output valid, output left_position, output right_position, input ready);
	modport sink (input valid, input left_position, input right_position, output ready);
endinterface

// File: src/weo_out_if.sv
// Result channel: pose before the step together with the step.
interface weo_out_if #(
	parameter int HEADING_BITS = weo_pkg::HEADING_BITS_DEF
);
	import weo_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [POSE_W-1:0] pose_x;
	logic signed [POSE_W-1:0] pose_y;
	logic [HEADING_BITS-1:0]  heading;
	logic signed [LIN_W-1:0]  linear_step;
	logic signed [ANG_W-1:0]  angular_step;

	modport source (
		output valid, output pose_x, output pose_y, output heading,
		output linear_step, output angular_step, input ready
	);
	modport sink (
		input valid, input pose_x, input pose_y, input heading,
		input linear_step, input angular_step, output ready
	);
endinterface

// File: src/wheel_encoder_odometry.sv
// Top level: differential-drive wheel odometry with one shared multiplier under a sequencer.
//
//   channel  direction  handshake      payload
//   cfg      in         valid/ready    index, data (register write, never stalls)
//   sample   in         valid/ready    left_position, right_position
//   odom     out        valid/ready    pose_x, pose_y, heading, linear_step, angular_step
//
// The sequencer takes no new sample until it is back in idle; the multiplies run in sequence
// on the one shared multiplier, twelve of them for the sine and cosine Horner chains.
// sample.ready is high only in the idle state. The result sits in an output register;
// the sequencer waits there only if the previous result has not yet been taken. Reset
// clears the pose, the held counts and the output registers.
module wheel_encoder_odometry #(
	parameter int ENCODER_BITS = weo_pkg::ENCODER_BITS_DEF,
	parameter int HEADING_BITS = weo_pkg::HEADING_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	weo_cfg_if.sink   cfg,
	weo_in_if.sink    sample,
	weo_out_if.source odom
);
	import weo_pkg::*;

	// Delta width covers a full count difference plus a span correction and negation.
	localparam int DW     = ((ENCODER_BITS > THR_W) ? ENCODER_BITS : THR_W) + 2;
	localparam int SUM_W  = DW + 1;
	localparam int MA_W   = (SUM_W > MUL_B_W) ? SUM_W : MUL_B_W;
	localparam int PW     = MA_W + MUL_B_W;
	localparam int HSH    = PHASE_W - HEADING_BITS;
	// Past this wheel difference the angular step saturates for any nonzero gain.
	localparam int DLIM_E = (ANG_W - 1) + HSH;
	localparam int DIFF_W = DLIM_E + 2;

	localparam logic signed [PW-1:0] RND_LIN  = PW'(1) <<< (LIN_SHIFT - 1);
	localparam logic signed [PW-1:0] RND_DIF  = PW'(1) <<< (DIF_SHIFT - 1);
	localparam logic signed [PW-1:0] RND_ANG  = PW'(1) <<< (HSH - 1);
	localparam logic signed [PW-1:0] RND_TRIG = PW'(1) <<< (TRIG_SHIFT - 1);
	localparam logic signed [PW-1:0] LIN_MAX  = (PW'(1) <<< (LIN_W - 1)) - PW'(1);
	localparam logic signed [PW-1:0] LIN_MIN  = -LIN_MAX - PW'(1);
	localparam logic signed [PW-1:0] ANG_MAX  = (PW'(1) <<< (ANG_W - 1)) - PW'(1);
	localparam logic signed [PW-1:0] ANG_MIN  = -ANG_MAX - PW'(1);
	localparam logic signed [PW-1:0] DIF_MAX  = PW'(1) <<< DLIM_E;
	localparam logic signed [PW-1:0] DIF_MIN  = -DIF_MAX;
	localparam logic signed [POSE_W-1:0] POSE_MAX = {1'b0, {(POSE_W-1){1'b1}}};
	localparam logic signed [POSE_W-1:0] POSE_MIN = {1'b1, {(POSE_W-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE, ST_DELTA, ST_SUMS, ST_MLIN, ST_MDIF, ST_PDIF, ST_MHI, ST_MLO, ST_PANG,
		ST_PUB, ST_TSQ, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_TEND, ST_MDX, ST_MDY, ST_PDY
	} state_t;

	state_t state_q;
	logic   primed_q;
	logic   out_vld_q;
	logic   is_cos_q;

	logic [ENCODER_BITS-1:0]  last_l_q, last_r_q;
	logic [ENCODER_BITS-1:0]  pos_l_q, pos_r_q;
	logic signed [POSE_W-1:0] odo_x_q, odo_y_q;
	logic [HEADING_BITS-1:0]  odo_h_q;

	logic signed [POSE_W-1:0] ox_q, oy_q;
	logic [HEADING_BITS-1:0]  oh_q;
	logic signed [LIN_W-1:0]  olin_q;
	logic signed [ANG_W-1:0]  oang_q;

	logic signed [DW-1:0]     dl_q, dr_q;
	logic signed [SUM_W-1:0]  sum_q, dif_q;
	logic signed [LIN_W-1:0]  lin_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [ANG_W-1:0]  ang_q;
	logic [TM_W-1:0]          x2_q;
	logic signed [TRIG_W-1:0] sin_q, cos_q;

	cfg_t cfg_v;

	mul_ctl_t                  mul_ctl;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]      p;

	logic signed [DW-1:0]     dl_n, dr_u, dr_n;
	logic signed [PW-1:0]     r_lin, r_dif, r_ang, r_trig;
	logic signed [LIN_W-1:0]  lin_sat;
	logic signed [DIFF_W-1:0] diff_sat;
	logic signed [ANG_W-1:0]  ang_sat;
	logic [TM_W-1:0]          hs;
	logic [PHASE_W-1:0]       phase;
	logic [1:0]               quad;
	logic [TM_W-1:0]          x_mag;
	logic [TM_W-1:0]          trig_mag;
	logic signed [TRIG_W-1:0] trig_val;
	logic signed [POSE_W-1:0] pose_sel;
	logic signed [POSE_W:0]   pose_sum;
	logic signed [POSE_W-1:0] pose_sat;
	logic                     pub_fire;

	weo_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_v)
	);

	weo_mul #(
		.MA_W (MA_W),
		.MB_W (MUL_B_W)
	) u_mul (
		.clk (clk),
		.ctl (mul_ctl),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p)
	);

	// Count difference with rollover removed.
	function automatic logic signed [DW-1:0] unroll(
		input logic [ENCODER_BITS-1:0] cur,
		input logic [ENCODER_BITS-1:0] prev,
		input logic [THR_W-1:0]        thr_in,
		input logic [SPAN_W-1:0]       span_in
	);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] thr;
		logic signed [DW-1:0] span;
		d    = signed'(DW'(cur)) - signed'(DW'(prev));
		thr  = signed'(DW'(thr_in));
		span = signed'(DW'(span_in));
		if ((d >= thr) || (d <= -thr)) begin
			unroll = d[DW-1] ? (d + span) : (d - span);
		end else begin
			unroll = d;
		end
	endfunction

	assign dl_n = unroll(pos_l_q, last_l_q, cfg_v.rollover_threshold, cfg_v.encoder_span);
	assign dr_u = unroll(pos_r_q, last_r_q, cfg_v.rollover_threshold, cfg_v.encoder_span);
	assign dr_n = cfg_v.right_reversed ? -dr_u : dr_u;

	// Round half up of the held product, then saturate each step.
	assign r_lin  = (p + RND_LIN) >>> LIN_SHIFT;
	assign r_dif  = (p + RND_DIF) >>> DIF_SHIFT;
	assign r_ang  = (p + RND_ANG) >>> HSH;
	assign r_trig = (p + RND_TRIG) >>> TRIG_SHIFT;

	always_comb begin
		if (r_lin > LIN_MAX) begin
			lin_sat = LIN_W'(LIN_MAX);
		end else if (r_lin < LIN_MIN) begin
			lin_sat = LIN_W'(LIN_MIN);
		end else begin
			lin_sat = LIN_W'(r_lin);
		end
		if (r_dif > DIF_MAX) begin
			diff_sat = DIFF_W'(DIF_MAX);
		end else if (r_dif < DIF_MIN) begin
			diff_sat = DIFF_W'(DIF_MIN);
		end else begin
			diff_sat = DIFF_W'(r_dif);
		end
		if (r_ang > ANG_MAX) begin
			ang_sat = ANG_W'(ANG_MAX);
		end else if (r_ang < ANG_MIN) begin
			ang_sat = ANG_W'(ANG_MIN);
		end else begin
			ang_sat = ANG_W'(r_ang);
		end
	end

	// Quarter-wave folding of the heading; the cosine is the sine a quarter turn later.
	assign hs    = p[TRIG_SHIFT +: TM_W];
	assign phase = {odo_h_q, {HSH{1'b0}}};
	assign quad  = phase[PHASE_W-1 -: 2] + {1'b0, is_cos_q};
	assign x_mag = quad[0] ? (Q30_ONE - {1'b0, phase[TRIG_SHIFT-1:0]})
		: {1'b0, phase[TRIG_SHIFT-1:0]};
	assign trig_mag = (hs > Q30_ONE) ? Q30_ONE : hs;
	assign trig_val = quad[1] ? -signed'({1'b0, trig_mag}) : signed'({1'b0, trig_mag});

	// Saturating pose update: x while the cosine product is held, y for the sine product.
	assign pose_sel = (state_q == ST_MDY) ? odo_x_q : odo_y_q;
	assign pose_sum = (POSE_W+1)'(pose_sel) + (POSE_W+1)'(r_trig);
	always_comb begin
		if (pose_sum[POSE_W] != pose_sum[POSE_W-1]) begin
			pose_sat = pose_sum[POSE_W] ? POSE_MIN : POSE_MAX;
		end else begin
			pose_sat = pose_sum[POSE_W-1:0];
		end
	end

	// The result register loads when the sequencer publishes and the old result is gone.
	assign pub_fire = (state_q == ST_PUB) && (!out_vld_q || odom.ready);

	// Multiplier operand selection for each sequencer step.
	always_comb begin
		mul_a       = '0;
		mul_b       = '0;
		mul_ctl.en  = 1'b0;
		mul_ctl.acc = 1'b0;
		unique case (state_q)
			ST_MLIN: begin
				mul_a      = MA_W'(sum_q);
				mul_b      = MUL_B_W'(cfg_v.metres_per_count);
				mul_ctl.en = 1'b1;
			end
			ST_MDIF: begin
				mul_a      = MA_W'(dif_q);
				mul_b      = MUL_B_W'(cfg_v.metres_per_count);
				mul_ctl.en = 1'b1;
			end
			ST_MHI: begin
				mul_a      = MA_W'(diff_q >>> SPLIT_W);
				mul_b      = MUL_B_W'(cfg_v.heading_gain);
				mul_ctl.en = 1'b1;
			end
			ST_MLO: begin
				mul_a       = MA_W'(diff_q[SPLIT_W-1:0]);
				mul_b       = MUL_B_W'(cfg_v.heading_gain);
				mul_ctl.en  = 1'b1;
				mul_ctl.acc = 1'b1;
			end
			ST_TSQ: begin
				mul_a      = MA_W'(x_mag);
				mul_b      = MUL_B_W'(x_mag);
				mul_ctl.en = 1'b1;
			end
			ST_T1: begin
				mul_a      = MA_W'(hs);
				mul_b      = HC0;
				mul_ctl.en = 1'b1;
			end
			ST_T2: begin
				mul_a      = MA_W'(x2_q);
				mul_b      = HC1 - MUL_B_W'(hs);
				mul_ctl.en = 1'b1;
			end
			ST_T3: begin
				mul_a      = MA_W'(x2_q);
				mul_b      = HC2 - MUL_B_W'(hs);
				mul_ctl.en = 1'b1;
			end
			ST_T4: begin
				mul_a      = MA_W'(x2_q);
				mul_b      = HC3 - MUL_B_W'(hs);
				mul_ctl.en = 1'b1;
			end
			ST_T5: begin
				mul_a      = MA_W'(x_mag);
				mul_b      = HC4 - MUL_B_W'(hs);
				mul_ctl.en = 1'b1;
			end
			ST_MDX: begin
				mul_a      = MA_W'(cos_q);
				mul_b      = MUL_B_W'(lin_q);
				mul_ctl.en = 1'b1;
			end
			ST_MDY: begin
				mul_a      = MA_W'(sin_q);
				mul_b      = MUL_B_W'(lin_q);
				mul_ctl.en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, odometry state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			primed_q  <= 1'b0;
			out_vld_q <= 1'b0;
			is_cos_q  <= 1'b0;
			last_l_q  <= '0;
			last_r_q  <= '0;
			odo_x_q   <= '0;
			odo_y_q   <= '0;
			odo_h_q   <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			oh_q      <= '0;
			olin_q    <= '0;
			oang_q    <= '0;
		end else begin
			if (pub_fire) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && odom.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						primed_q <= 1'b1;
						if (primed_q) begin
							state_q <= ST_DELTA;
						end else begin
							// First sample latches the counts; its result carries a zero step.
							last_l_q <= sample.left_position;
							last_r_q <= sample.right_position;
							state_q  <= ST_PUB;
						end
					end
				end
				ST_DELTA: begin
					last_l_q <= pos_l_q;
					last_r_q <= pos_r_q;
					state_q  <= ST_SUMS;
				end
				ST_SUMS: state_q <= ST_MLIN;
				ST_MLIN: state_q <= ST_MDIF;
				ST_MDIF: state_q <= ST_PDIF;
				ST_PDIF: state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_PANG;
				ST_PANG: state_q <= ST_PUB;
				ST_PUB: begin
					if (pub_fire) begin
						ox_q     <= odo_x_q;
						oy_q     <= odo_y_q;
						oh_q     <= odo_h_q;
						olin_q   <= lin_q;
						oang_q   <= ang_q;
						is_cos_q <= 1'b0;
						state_q  <= ST_TSQ;
					end
				end
				ST_TSQ: state_q <= ST_T1;
				ST_T1:  state_q <= ST_T2;
				ST_T2:  state_q <= ST_T3;
				ST_T3:  state_q <= ST_T4;
				ST_T4:  state_q <= ST_T5;
				ST_T5:  state_q <= ST_TEND;
				ST_TEND: begin
					if (is_cos_q) begin
						state_q <= ST_MDX;
					end else begin
						is_cos_q <= 1'b1;
						state_q  <= ST_TSQ;
					end
				end
				ST_MDX: state_q <= ST_MDY;
				ST_MDY: begin
					odo_x_q <= pose_sat;
					state_q <= ST_PDY;
				end
				ST_PDY: begin
					odo_y_q <= pose_sat;
					odo_h_q <= odo_h_q + HEADING_BITS'(ang_q);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the step and trig evaluation.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					pos_l_q <= sample.left_position;
					pos_r_q <= sample.right_position;
					lin_q   <= '0;
					ang_q   <= '0;
				end
			end
			ST_DELTA: begin
				dl_q <= dl_n;
				dr_q <= dr_n;
			end
			ST_SUMS: begin
				sum_q <= SUM_W'(dl_q) + SUM_W'(dr_q);
				dif_q <= SUM_W'(dr_q) - SUM_W'(dl_q);
			end
			ST_MDIF: lin_q <= lin_sat;
			ST_PDIF: diff_q <= diff_sat;
			ST_PANG: ang_q <= ang_sat;
			ST_T1:   x2_q <= hs;
			ST_TEND: begin
				if (is_cos_q) begin
					cos_q <= trig_val;
				end else begin
					sin_q <= trig_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign sample.ready       = (state_q == ST_IDLE);
	assign odom.valid         = out_vld_q;
	assign odom.pose_x        = ox_q;
	assign odom.pose_y        = oy_q;
	assign odom.heading       = oh_q;
	assign odom.linear_step   = olin_q;
	assign odom.angular_step  = oang_q;

endmodule

// File: src/weo_cfg_regs.sv
// Configuration register file of the odometry block.
module weo_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	weo_cfg_if.sink       cfg,
	output weo_pkg::cfg_t regs
);
	import weo_pkg::*;

	cfg_t regs_q;

	// The port never stalls; a write to an index past the list is dropped.
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.metres_per_count   <= RST_METRES_PER_COUNT;
			regs_q.heading_gain       <= RST_HEADING_GAIN;
			regs_q.rollover_threshold <= RST_ROLLOVER_THRESHOLD;
			regs_q.encoder_span       <= RST_ENCODER_SPAN;
			regs_q.right_reversed     <= RST_RIGHT_REVERSED;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_METRES_PER_COUNT:   regs_q.metres_per_count <= cfg.data[MPC_W-1:0];
				REG_HEADING_GAIN:       regs_q.heading_gain <= cfg.data[GAIN_W-1:0];
				REG_ROLLOVER_THRESHOLD: regs_q.rollover_threshold <= cfg.data[THR_W-1:0];
				REG_ENCODER_SPAN:       regs_q.encoder_span <= cfg.data[SPAN_W-1:0];
				REG_RIGHT_REVERSED:     regs_q.right_reversed <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/weo_mul.sv
// Shared signed multiplier with a registered product and an optional shifted accumulate.
module weo_mul #(
	parameter int MA_W = weo_pkg::MUL_B_W,
	parameter int MB_W = weo_pkg::MUL_B_W
) (
	input  logic                          clk,
	input  weo_pkg::mul_ctl_t             ctl,
	input  logic signed [MA_W-1:0]        a,
	input  logic signed [MB_W-1:0]        b,
	output logic signed [MA_W+MB_W-1:0]   p
);
	import weo_pkg::*;

	localparam int PW = MA_W + MB_W;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] p_q;

	assign prod = PW'(a) * PW'(b);
	assign p    = p_q;

	// With accumulate set, the held product is the upper partial product of a split operand.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			p_q <= prod + (ctl.acc ? (p_q <<< SPLIT_W) : PW'(0));
		end
	end

endmodule

// File: tb/sv/wheel_encoder_odometry_tb.sv
// Self-checking testbench of the wheel encoder odometry block with its own pose predictor.
module wheel_encoder_odometry_tb;
	import weo_pkg::*;

	localparam int EB = ENCODER_BITS_DEF;
	localparam int HB = HEADING_BITS_DEF;
	localparam int ENC_MAX = (1 << EB) - 1;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_STALL = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;

	// Idle patterns of the two sides.
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [EB-1:0] left;
		logic [EB-1:0] right;
	} wheel_counts_t;

	typedef struct packed {
		logic signed [POSE_W-1:0] pose_x;
		logic signed [POSE_W-1:0] pose_y;
		logic [HB-1:0]            heading;
		logic signed [LIN_W-1:0]  linear_step;
		logic signed [ANG_W-1:0]  angular_step;
	} pose_step_t;

	logic clk;
	logic arst_n;

	weo_cfg_if cfg_ch ();
	weo_in_if  sample_ch ();
	weo_out_if odom_ch ();

	wheel_encoder_odometry dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.odom   (odom_ch)
	);

	// Predictor copy of the registers and of the odometry state.
	longint cfg_mpc, cfg_gain, cfg_thr, cfg_span, cfg_reversed;
	logic [EB-1:0] last_left, last_right;
	bit            odo_primed;
	longint        odo_x, odo_y;
	logic [HB-1:0] odo_heading;

	wheel_counts_t count_q[$];
	pose_step_t    predicted_poses[$];
	int  samples_queued;
	int  samples_taken;
	int  results_seen;
	int  fail_count;
	int  idle_cycles;
	int  send_idle_pct;
	int  stall_pct;
	int  stall_left;
	int  track_left, track_right;
	logic sample_taken;

	// Round half up of v / 2^s.
	function automatic longint round_shr(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Count difference with counter rollover undone.
	function automatic longint unwrap_count(input logic [EB-1:0] now, input logic [EB-1:0] was);
		longint a, b, d, mag;
		a = now;
		b = was;
		d = a - b;
		mag = d < 0 ? -d : d;
		if (mag >= cfg_thr)
			return d < 0 ? d + cfg_span : d - cfg_span;
		return d;
	endfunction

	// Sine of a 32-bit turn phase in signed Q2.30, quarter-wave polynomial by Horner.
	function automatic longint sine_q30(input logic [PHASE_W-1:0] phase);
		logic [63:0] x, x2, t;
		x = {34'b0, phase[29:0]};
		if (phase[30])
			x = (64'd1 << TRIG_SHIFT) - x;
		x2 = (x * x) >> TRIG_SHIFT;
		t = HC0;
		t = HC1 - ((x2 * t) >> TRIG_SHIFT);
		t = HC2 - ((x2 * t) >> TRIG_SHIFT);
		t = HC3 - ((x2 * t) >> TRIG_SHIFT);
		t = HC4 - ((x2 * t) >> TRIG_SHIFT);
		t = (x * t) >> TRIG_SHIFT;
		if (t > Q30_ONE)
			t = Q30_ONE;
		return phase[31] ? -longint'(t) : longint'(t);
	endfunction

	// One encoder sample: returns the pose before the step and the step, then advances the pose.
	function automatic pose_step_t advance_odometry(input logic [EB-1:0] left,
			input logic [EB-1:0] right);
		pose_step_t r;
		longint dl, dr, lin, diff, ang, s, c;
		logic [PHASE_W-1:0] phase;
		lin = 0;
		ang = 0;
		if (odo_primed) begin
			dl = unwrap_count(left, last_left);
			dr = unwrap_count(right, last_right);
			if (cfg_reversed != 0)
				dr = -dr;
			lin = clip(round_shr((dl + dr) * cfg_mpc, LIN_SHIFT),
				-(longint'(1) <<< (LIN_W - 1)), (longint'(1) <<< (LIN_W - 1)) - 1);
			diff = clip(round_shr((dr - dl) * cfg_mpc, DIF_SHIFT),
				-(longint'(1) <<< 40), longint'(1) <<< 40);
			ang = clip(round_shr(diff * cfg_gain, 32 - HB),
				-(longint'(1) <<< (ANG_W - 1)), (longint'(1) <<< (ANG_W - 1)) - 1);
		end
		last_left = left;
		last_right = right;
		odo_primed = 1'b1;

		r.pose_x = odo_x[POSE_W-1:0];
		r.pose_y = odo_y[POSE_W-1:0];
		r.heading = odo_heading;
		r.linear_step = lin[LIN_W-1:0];
		r.angular_step = ang[ANG_W-1:0];

		// Move along the old heading, then turn.
		phase = {odo_heading, {(PHASE_W - HB){1'b0}}};
		s = sine_q30(phase);
		c = sine_q30(phase + 32'h4000_0000);
		odo_x = clip(odo_x + round_shr(lin * c, TRIG_SHIFT),
			-(longint'(1) <<< (POSE_W - 1)), (longint'(1) <<< (POSE_W - 1)) - 1);
		odo_y = clip(odo_y + round_shr(lin * s, TRIG_SHIFT),
			-(longint'(1) <<< (POSE_W - 1)), (longint'(1) <<< (POSE_W - 1)) - 1);
		odo_heading = odo_heading + ang[HB-1:0];
		return r;
	endfunction

	// Clock, and every input at a known value from the start.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.left_position = '0;
		sample_ch.right_position = '0;
		odom_ch.ready = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample driver: offers the next pending item, holding it until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_ch.valid || sample_taken) begin
				if (count_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_ch.valid <= 1'b1;
					sample_ch.left_position <= count_q[0].left;
					sample_ch.right_position <= count_q[0].right;
					void'(count_q.pop_front());
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				odom_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				odom_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Monitor: predicts on each accepted sample, checks each accepted result, and watches for hangs.
	always @(posedge clk) begin
		pose_step_t got, want;
		if (arst_n) begin
			sample_taken <= sample_ch.valid && sample_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_METRES_PER_COUNT:   cfg_mpc = cfg_ch.data[MPC_W-1:0];
					REG_HEADING_GAIN:       cfg_gain = cfg_ch.data[GAIN_W-1:0];
					REG_ROLLOVER_THRESHOLD: cfg_thr = cfg_ch.data[THR_W-1:0];
					REG_ENCODER_SPAN:       cfg_span = cfg_ch.data[SPAN_W-1:0];
					REG_RIGHT_REVERSED:     cfg_reversed = cfg_ch.data[0];
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				want = advance_odometry(sample_ch.left_position, sample_ch.right_position);
				predicted_poses = {predicted_poses, want};
				samples_taken++;
			end
			if (odom_ch.valid && odom_ch.ready) begin
				got.pose_x = odom_ch.pose_x;
				got.pose_y = odom_ch.pose_y;
				got.heading = odom_ch.heading;
				got.linear_step = odom_ch.linear_step;
				got.angular_step = odom_ch.angular_step;
				results_seen++;
				if (predicted_poses.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d arrived with no sample pending: x=%0d y=%0d",
							results_seen, got.pose_x, got.pose_y);
				end else begin
					want = predicted_poses.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d mismatch: expected x=%0d y=%0d hdg=%0d lin=%0d ang=%0d",
								results_seen, want.pose_x, want.pose_y, want.heading,
								want.linear_step, want.angular_step);
							$display("    got x=%0d y=%0d hdg=%0d lin=%0d ang=%0d",
								got.pose_x, got.pose_y, got.heading, got.linear_step,
								got.angular_step);
						end
					end
				end
			end
			if ((sample_ch.valid && sample_ch.ready) || (odom_ch.valid && odom_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("no item moved for %0d cycles", IDLE_LIMIT);
					$display("[wheel_encoder_odometry] ERROR");
					$finish;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every queued sample is taken and every result has come back.
	task automatic wait_drained();
		do @(negedge clk); while (samples_taken != samples_queued || predicted_poses.size() != 0);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		@(posedge clk);
		send_idle_pct = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 13 : 0;
		stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 13 : 0;
	endtask

	task automatic queue_counts(input int l, input int r);
		wheel_counts_t w;
		w.left = l[EB-1:0];
		w.right = r[EB-1:0];
		count_q = {count_q, w};
		track_left = l & ENC_MAX;
		track_right = r & ENC_MAX;
		samples_queued++;
	endtask

	// Mostly smooth driving around the threshold, some jumps across rollover, some noise.
	task automatic queue_motion(input int count);
		int kind;
		repeat (count) begin
			kind = $urandom_range(99);
			if (kind < 5)
				queue_counts(track_left, track_right);
			else if (kind < 70)
				queue_counts(track_left + int'($urandom_range(3000)) - 1500,
					track_right + int'($urandom_range(3000)) - 1500);
			else if (kind < 85)
				queue_counts($urandom_range(1) ? ENC_MAX - int'($urandom_range(300))
					: int'($urandom_range(300)),
					$urandom_range(1) ? ENC_MAX - int'($urandom_range(300))
					: int'($urandom_range(300)));
			else
				queue_counts(int'($urandom_range(ENC_MAX)), int'($urandom_range(ENC_MAX)));
		end
	endtask

	// Test sequence.
	initial begin
		cfg_mpc = RST_METRES_PER_COUNT;
		cfg_gain = RST_HEADING_GAIN;
		cfg_thr = RST_ROLLOVER_THRESHOLD;
		cfg_span = RST_ENCODER_SPAN;
		cfg_reversed = RST_RIGHT_REVERSED;
		last_left = '0;
		last_right = '0;
		odo_primed = 1'b0;
		odo_x = 0;
		odo_y = 0;
		odo_heading = '0;
		samples_queued = 0;
		samples_taken = 0;
		results_seen = 0;
		fail_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		stall_left = 0;
		track_left = 0;
		track_right = 0;
		sample_taken = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// First sample only latches; then steps around the default threshold and the extremes.
		queue_counts(0, 0);
		queue_counts(500, ENC_MAX - 500);
		queue_counts(500, ENC_MAX - 500);
		queue_counts(1499, ENC_MAX - 1499);
		queue_counts(2499, ENC_MAX - 2499);
		queue_counts(1499, ENC_MAX - 499);
		queue_counts(ENC_MAX, 0);
		queue_counts(0, ENC_MAX);
		queue_counts(ENC_MAX, ENC_MAX);
		queue_counts(0, 0);
		wait_drained();

		// Zero threshold and zero span: every delta counts as wrapped, and nothing is changed.
		write_reg(REG_ROLLOVER_THRESHOLD, '0);
		write_reg(REG_ENCODER_SPAN, '0);
		queue_counts(0, 0);
		queue_counts(700, 300);
		queue_counts(ENC_MAX, 100);
		wait_drained();

		// Largest scales, with bits beyond the register widths and writes past the last index.
		write_reg(REG_METRES_PER_COUNT, 24'hFF_FFFF);
		write_reg(REG_HEADING_GAIN, 24'hFF_FFFF);
		write_reg(REG_ROLLOVER_THRESHOLD, 24'hFF_FFFF);
		write_reg(REG_ENCODER_SPAN, 24'hFF_8001);
		write_reg(REG_RIGHT_REVERSED, 24'hFF_FFFE);
		for (int i = REG_RIGHT_REVERSED + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(24'hFF_FFFF)));
		queue_counts(0, 0);
		queue_counts(ENC_MAX, 0);
		queue_counts(0, ENC_MAX);
		queue_counts(ENC_MAX, ENC_MAX);
		queue_counts(16384, 0);
		queue_counts(0, 16384);

		// Random phases under several register settings and idle patterns.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin
					write_reg(REG_METRES_PER_COUNT, CFG_DATA_W'((1 << MPC_W) - 1));
					write_reg(REG_HEADING_GAIN, CFG_DATA_W'((1 << GAIN_W) - 1));
					write_reg(REG_ROLLOVER_THRESHOLD, CFG_DATA_W'((1 << THR_W) - 1));
					write_reg(REG_ENCODER_SPAN, CFG_DATA_W'((1 << SPAN_W) - 1));
					write_reg(REG_RIGHT_REVERSED, '0);
				end
				1: begin
					write_reg(REG_METRES_PER_COUNT, '0);
					write_reg(REG_HEADING_GAIN, '0);
					write_reg(REG_ROLLOVER_THRESHOLD, CFG_DATA_W'(1));
					write_reg(REG_ENCODER_SPAN, CFG_DATA_W'(1));
					write_reg(REG_RIGHT_REVERSED, CFG_DATA_W'(1));
				end
				2: begin
					write_reg(REG_METRES_PER_COUNT, CFG_DATA_W'(RST_METRES_PER_COUNT));
					write_reg(REG_HEADING_GAIN, CFG_DATA_W'(RST_HEADING_GAIN));
					write_reg(REG_ROLLOVER_THRESHOLD, CFG_DATA_W'(RST_ROLLOVER_THRESHOLD));
					write_reg(REG_ENCODER_SPAN, CFG_DATA_W'(RST_ENCODER_SPAN));
					write_reg(REG_RIGHT_REVERSED, CFG_DATA_W'(RST_RIGHT_REVERSED));
				end
				default: begin
					write_reg(REG_METRES_PER_COUNT, CFG_DATA_W'($urandom_range(1)
						? $urandom_range(1000, 60000) : $urandom_range((1 << MPC_W) - 1)));
					write_reg(REG_HEADING_GAIN, CFG_DATA_W'($urandom_range((1 << GAIN_W) - 1)));
					write_reg(REG_ROLLOVER_THRESHOLD, CFG_DATA_W'($urandom_range(100, 20000)));
					write_reg(REG_ENCODER_SPAN, CFG_DATA_W'($urandom_range(1) ? ENC_MAX
						: $urandom_range(1, (1 << SPAN_W) - 1)));
					write_reg(REG_RIGHT_REVERSED, CFG_DATA_W'($urandom_range(1)));
				end
			endcase
			set_idle(idle_mode_t'(p % 4));
			queue_motion(PHASE_ITEMS);
			// The receiver holds off long enough for the block to back up into its input.
			if (p == 4) begin
				@(posedge clk);
				stall_left = LONG_STALL;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && predicted_poses.size() == 0)
			$display("[wheel_encoder_odometry] OK");
		else
			$display("[wheel_encoder_odometry] ERROR");
		$finish;
	end

endmodule

// File: files.f
src/weo_pkg.sv
src/weo_cfg_if.sv
src/weo_in_if.sv
src/weo_out_if.sv
src/weo_cfg_regs.sv
src/weo_mul.sv
src/wheel_encoder_odometry.sv
tb/sv/wheel_encoder_odometry_tb.sv
